@@ sv/brf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the Brent-Dekker root finder: Q31.32 types, constants and
// saturating arithmetic helpers. Used by brf_mdu and brent_root_finder_unit.
package brf_pkg;

  localparam int FRAC_BITS = 32;
  localparam int DW        = 64;
  localparam int TOL_W     = 63;
  localparam int CNT_W     = $clog2(DW);

  typedef logic signed [DW-1:0] q_t;

  localparam q_t Q_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam q_t Q_ONE = q_t'(1) <<< FRAC_BITS;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LEFT  = 2'd1,
    PH_RIGHT = 2'd2,
    PH_ITER  = 2'd3
  } phase_t;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_VALUE = 1'b1
  } req_t;

  // Control from the sequencer to the shared multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctl_t;

  function automatic logic [DW-1:0] f_mag(input q_t x);
    return x[DW-1] ? ({DW{1'b0}} - DW'(x)) : DW'(x);
  endfunction

  function automatic q_t f_pack(input logic neg, input logic [DW-1:0] m);
    if (neg) begin
      return m[DW-1] ? Q_MIN : q_t'({DW{1'b0}} - m);
    end
    return m[DW-1] ? Q_MAX : q_t'(m);
  endfunction

  function automatic q_t f_sabs(input q_t x);
    return f_pack(1'b0, f_mag(x));
  endfunction

  function automatic q_t f_sadd(input q_t x, input q_t y);
    logic signed [DW:0] s;
    s = {x[DW-1], x} + {y[DW-1], y};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? Q_MIN : Q_MAX;
    end
    return s[DW-1:0];
  endfunction

  function automatic q_t f_ssub(input q_t x, input q_t y);
    logic signed [DW:0] s;
    s = {x[DW-1], x} - {y[DW-1], y};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? Q_MIN : Q_MAX;
    end
    return s[DW-1:0];
  endfunction

endpackage

@@ sv/brent_root_finder_unit.sv @@
`timescale 1ns / 1ps
// Brent-Dekker bracketing root finder, Q31.32, with a shared multiply/divide.
// Depends on brf_pkg and brf_mdu.
// A start item or f(left) is registered as the result, then moves to the output
// register once that is free. An iteration goes straight to the result on
// convergence and through S_STEP on bisection; otherwise each multiply or
// divide runs in turn on the shared bit-serial unit, and a divide that saturates
// at once skips the serial run. One transaction is in work at a time and in_ready
// stays low until its result is registered. Synchronous active-low reset clears
// the state and sets the tolerance to 65536.
module brent_root_finder_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [brf_pkg::TOL_W-1:0] cfg_abs_tolerance,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req_type,
  input  brf_pkg::q_t               in_left_end,
  input  brf_pkg::q_t               in_right_end,
  input  brf_pkg::q_t               in_fun_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output brf_pkg::q_t               out_point,
  output logic                      out_finished
);
  import brf_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE  = 23'h000001,
    S_SWAP  = 23'h000002,
    S_XM    = 23'h000004,
    S_CONV  = 23'h000008,
    S_DQ    = 23'h000010,
    S_DR    = 23'h000020,
    S_DS    = 23'h000040,
    S_M1    = 23'h000080,
    S_M2    = 23'h000100,
    S_M3    = 23'h000200,
    S_M4    = 23'h000400,
    S_M5    = 23'h000800,
    S_M6    = 23'h001000,
    S_DSEC  = 23'h002000,
    S_MSEC  = 23'h004000,
    S_PQ    = 23'h008000,
    S_M8    = 23'h010000,
    S_M9    = 23'h020000,
    S_M10   = 23'h040000,
    S_ACC   = 23'h080000,
    S_DSTEP = 23'h100000,
    S_STEP  = 23'h200000,
    S_EMIT  = 23'h400000
  } state_t;

  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [TOL_W-1:0]   tol_r;
  q_t a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  q_t fa_r, fa_nxt, fb_r, fb_nxt, fc_r, fc_nxt;
  q_t d_r, d_nxt, e_r, e_nxt;
  q_t xm_r, xm_nxt, p_r, p_nxt, q_r, q_nxt, r_r, r_nxt, s_r, s_nxt, t_r, t_nxt;
  q_t                 res_point_r, res_point_nxt;
  logic               res_fin_r, res_fin_nxt;
  logic               issued_r, issued_nxt;
  logic               out_valid_r;
  q_t                 out_point_r;
  logic               out_fin_r;

  md_ctl_t            md_ctl;
  q_t                 md_x, md_y, md_res;
  logic               md_done;
  logic               op_state, emit_go;

  q_t                 tol1, xm2, d_in, bstep, eq_abs;
  logic signed [DW:0] diff;

  assign tol1   = q_t'({2'b00, tol_r[TOL_W-1:1]}) + q_t'(1);
  assign xm2    = f_sadd(xm_r, xm_r);
  assign diff   = {c_r[DW-1], c_r} - {b_r[DW-1], b_r};
  assign eq_abs = f_sabs(r_r);

  always_comb begin
    op_state = 1'b0;
    case (state_r)
      S_DQ, S_DR, S_DS, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
      S_DSEC, S_MSEC, S_M8, S_M9, S_M10, S_DSTEP: op_state = 1'b1;
      default: op_state = 1'b0;
    endcase
  end

  // Operand selection for the shared unit.
  always_comb begin
    md_ctl.start  = op_state && !issued_r;
    md_ctl.is_div = 1'b0;
    md_x = xm2;
    md_y = q_r;
    case (state_r)
      S_DQ: begin
        md_ctl.is_div = 1'b1; md_x = fa_r; md_y = fc_r;
      end
      S_DR: begin
        md_ctl.is_div = 1'b1; md_x = fb_r; md_y = fc_r;
      end
      S_DS, S_DSEC: begin
        md_ctl.is_div = 1'b1; md_x = fb_r; md_y = fa_r;
      end
      S_DSTEP: begin
        md_ctl.is_div = 1'b1; md_x = p_r; md_y = q_r;
      end
      S_M1:   begin md_x = xm2; md_y = q_r; end
      S_M2:   begin md_x = t_r; md_y = f_ssub(q_r, r_r); end
      S_M3:   begin md_x = f_ssub(b_r, a_r); md_y = f_ssub(r_r, Q_ONE); end
      S_M4:   begin md_x = s_r; md_y = t_r; end
      S_M5:   begin md_x = f_ssub(q_r, Q_ONE); md_y = f_ssub(r_r, Q_ONE); end
      S_M6:   begin md_x = t_r; md_y = f_ssub(s_r, Q_ONE); end
      S_MSEC: begin md_x = xm2; md_y = s_r; end
      S_M8:   begin md_x = f_sadd(xm2, xm_r); md_y = q_r; end
      S_M9:   begin md_x = tol1; md_y = q_r; end
      S_M10:  begin md_x = e_r; md_y = q_r; end
      default: begin
        md_x = xm2; md_y = q_r;
      end
    endcase
  end

  brf_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (md_ctl),
    .x     (md_x),
    .y     (md_y),
    .done  (md_done),
    .res   (md_res)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign d_in      = f_ssub(b_r, a_r);

  always_comb begin
    if (f_sabs(d_r) > tol1) begin
      bstep = f_sadd(b_r, d_r);
    end else if (!xm_r[DW-1]) begin
      bstep = f_sadd(b_r, tol1);
    end else begin
      bstep = f_ssub(b_r, tol1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r;
    fa_nxt = fa_r; fb_nxt = fb_r; fc_nxt = fc_r;
    d_nxt = d_r; e_nxt = e_r;
    xm_nxt = xm_r; p_nxt = p_r; q_nxt = q_r; r_nxt = r_r; s_nxt = s_r; t_nxt = t_r;
    res_point_nxt = res_point_r;
    res_fin_nxt   = res_fin_r;
    issued_nxt    = issued_r;

    if (md_ctl.start) begin
      issued_nxt = 1'b1;
    end
    if (md_done) begin
      issued_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_START) begin
            a_nxt         = in_left_end;
            b_nxt         = in_right_end;
            phase_nxt     = PH_LEFT;
            res_point_nxt = in_left_end;
            res_fin_nxt   = 1'b0;
            state_nxt     = S_EMIT;
          end else begin
            case (phase_r)
              PH_LEFT: begin
                fa_nxt        = in_fun_value;
                phase_nxt     = PH_RIGHT;
                res_point_nxt = b_r;
                res_fin_nxt   = 1'b0;
                state_nxt     = S_EMIT;
              end
              PH_RIGHT: begin
                fb_nxt    = in_fun_value;
                c_nxt     = a_r;
                fc_nxt    = fa_r;
                d_nxt     = d_in;
                e_nxt     = d_in;
                state_nxt = S_SWAP;
              end
              PH_ITER: begin
                fb_nxt = in_fun_value;
                // Re-bracket only when f(b) and f(c) share a nonzero sign.
                if ((in_fun_value > 0 && fc_r > 0) || (in_fun_value < 0 && fc_r < 0)) begin
                  c_nxt  = a_r;
                  fc_nxt = fa_r;
                  d_nxt  = d_in;
                  e_nxt  = d_in;
                end
                state_nxt = S_SWAP;
              end
              default: state_nxt = S_IDLE;
            endcase
          end
        end
      end
      S_SWAP: begin
        if (f_sabs(fc_r) < f_sabs(fb_r)) begin
          a_nxt  = b_r;  b_nxt  = c_r;  c_nxt  = b_r;
          fa_nxt = fb_r; fb_nxt = fc_r; fc_nxt = fb_r;
        end
        state_nxt = S_XM;
      end
      S_XM: begin
        xm_nxt    = diff[DW:1];
        state_nxt = S_CONV;
      end
      S_CONV: begin
        if (f_sabs(xm_r) <= tol1 || fb_r == '0) begin
          res_point_nxt = b_r;
          res_fin_nxt   = 1'b1;
          phase_nxt     = PH_IDLE;
          state_nxt     = S_EMIT;
        end else if (f_sabs(e_r) < tol1 || f_sabs(fa_r) < f_sabs(fb_r)) begin
          d_nxt     = xm_r;
          e_nxt     = xm_r;
          state_nxt = S_STEP;
        end else if (a_r != c_r) begin
          state_nxt = S_DQ;
        end else begin
          state_nxt = S_DSEC;
        end
      end
      S_DQ:   if (md_done) begin q_nxt = md_res; state_nxt = S_DR;   end
      S_DR:   if (md_done) begin r_nxt = md_res; state_nxt = S_DS;   end
      S_DS:   if (md_done) begin s_nxt = md_res; state_nxt = S_M1;   end
      S_M1:   if (md_done) begin t_nxt = md_res; state_nxt = S_M2;   end
      S_M2:   if (md_done) begin t_nxt = md_res; state_nxt = S_M3;   end
      S_M3: begin
        if (md_done) begin
          t_nxt     = f_ssub(t_r, md_res);
          state_nxt = S_M4;
        end
      end
      S_M4:   if (md_done) begin p_nxt = md_res; state_nxt = S_M5;   end
      S_M5:   if (md_done) begin t_nxt = md_res; state_nxt = S_M6;   end
      S_M6:   if (md_done) begin q_nxt = md_res; state_nxt = S_PQ;   end
      S_DSEC: if (md_done) begin s_nxt = md_res; state_nxt = S_MSEC; end
      S_MSEC: begin
        if (md_done) begin
          p_nxt     = md_res;
          q_nxt     = f_ssub(Q_ONE, s_r);
          state_nxt = S_PQ;
        end
      end
      S_PQ: begin
        if (p_r > 0) begin
          q_nxt = f_ssub(q_t'(0), q_r);
        end
        p_nxt     = f_sabs(p_r);
        state_nxt = S_M8;
      end
      S_M8:   if (md_done) begin t_nxt = md_res; state_nxt = S_M9;   end
      S_M9: begin
        if (md_done) begin
          t_nxt     = f_ssub(t_r, f_sabs(md_res));
          state_nxt = S_M10;
        end
      end
      S_M10:  if (md_done) begin r_nxt = md_res; state_nxt = S_ACC;  end
      S_ACC: begin
        // Accept the interpolation only if it stays well inside the bracket.
        if (f_sadd(p_r, p_r) < t_r &&
            p_r < q_t'({1'b0, eq_abs[DW-1:1]})) begin
          e_nxt     = d_r;
          state_nxt = S_DSTEP;
        end else begin
          d_nxt     = xm_r;
          e_nxt     = xm_r;
          state_nxt = S_STEP;
        end
      end
      S_DSTEP: if (md_done) begin d_nxt = md_res; state_nxt = S_STEP; end
      S_STEP: begin
        a_nxt         = b_r;
        fa_nxt        = fb_r;
        b_nxt         = bstep;
        res_point_nxt = bstep;
        res_fin_nxt   = 1'b0;
        phase_nxt     = PH_ITER;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      tol_r       <= TOL_W'(65536);
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      a_r <= '0; b_r <= '0; c_r <= '0;
      fa_r <= '0; fb_r <= '0; fc_r <= '0;
      d_r <= '0; e_r <= '0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      issued_r <= issued_nxt;
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_abs_tolerance;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt;
      fa_r <= fa_nxt; fb_r <= fb_nxt; fc_r <= fc_nxt;
      d_r <= d_nxt; e_r <= e_nxt;
    end
    xm_r <= xm_nxt; p_r <= p_nxt; q_r <= q_nxt; r_r <= r_nxt;
    s_r <= s_nxt; t_r <= t_nxt;
    res_point_r <= res_point_nxt;
    res_fin_r   <= res_fin_nxt;
    if (emit_go) begin
      out_point_r <= res_point_r;
      out_fin_r   <= res_fin_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_point    = out_point_r;
  assign out_finished = out_fin_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
    issued_r && !md_done |=> $stable(state_r))
    else $error("sequencer moved while the shared unit was busy");

  a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> issued_r)
    else $error("shared unit finished without a request");

  a_step_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |=> phase_r == PH_ITER && state_r == S_EMIT)
    else $error("new iterate not followed by a result");

endmodule

@@ sv/brf_mdu.sv @@
`timescale 1ns / 1ps
// Shared bit-serial multiply/divide unit for the root finder: saturating
// Q31.32 product and quotient, one bit per cycle. Depends on brf_pkg.
module brf_mdu (
  input  logic             clk,
  input  logic             rst_n,
  input  brf_pkg::md_ctl_t ctl,
  input  brf_pkg::q_t      x,
  input  brf_pkg::q_t      y,
  output logic             done,
  output brf_pkg::q_t      res
);
  import brf_pkg::*;

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_RUN  = 3'b010,
    MD_FIN  = 3'b100
  } md_state_t;

  md_state_t        st_r, st_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             div_r, div_nxt;
  logic             neg_r, neg_nxt;
  logic [DW-1:0]    hi_r, hi_nxt;
  logic [DW-1:0]    lo_r, lo_nxt;
  logic [DW-1:0]    ud_r, ud_nxt;
  logic             done_r, done_nxt;
  q_t               res_r, res_nxt;

  logic [DW-1:0]    ux, uy, dhi;
  logic [DW:0]      sum, rem;
  logic             ge, ovf;
  logic [2*DW-1:0]  prod;
  logic [DW-1:0]    rlo;

  always_comb begin
    ux   = f_mag(x);
    uy   = f_mag(y);
    dhi  = ux >> (DW - FRAC_BITS);
    sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, ud_r} : {(DW+1){1'b0}});
    rem  = {hi_r, lo_r[DW-1]};
    ge   = rem[DW] | (rem[DW-1:0] >= ud_r);
    prod = {hi_r, lo_r};
    ovf  = |prod[2*DW-1:DW+FRAC_BITS];
    rlo  = ovf ? {DW{1'b1}} : prod[FRAC_BITS +: DW];

    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    ud_nxt   = ud_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;

    case (st_r)
      MD_IDLE: begin
        if (ctl.start) begin
          div_nxt = ctl.is_div;
          neg_nxt = x[DW-1] ^ y[DW-1];
          cnt_nxt = '0;
          if (ctl.is_div) begin
            // A zero divisor or an oversized quotient finishes at once.
            if (uy == '0) begin
              done_nxt = 1'b1;
              res_nxt  = (ux == '0) ? q_t'(0) : (x[DW-1] ? Q_MIN : Q_MAX);
            end else if (dhi >= uy) begin
              done_nxt = 1'b1;
              res_nxt  = f_pack(x[DW-1] ^ y[DW-1], {DW{1'b1}});
            end else begin
              hi_nxt = dhi;
              lo_nxt = ux << FRAC_BITS;
              ud_nxt = uy;
              st_nxt = MD_RUN;
            end
          end else begin
            hi_nxt = '0;
            lo_nxt = uy;
            ud_nxt = ux;
            st_nxt = MD_RUN;
          end
        end
      end
      MD_RUN: begin
        if (div_r) begin
          hi_nxt = ge ? (rem[DW-1:0] - ud_r) : rem[DW-1:0];
          lo_nxt = {lo_r[DW-2:0], ge};
        end else begin
          hi_nxt = sum[DW:1];
          lo_nxt = {sum[0], lo_r[DW-1:1]};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == {CNT_W{1'b1}}) begin
          st_nxt = MD_FIN;
        end
      end
      MD_FIN: begin
        done_nxt = 1'b1;
        res_nxt  = div_r ? f_pack(neg_r, lo_r) : f_pack(neg_r, rlo);
        st_nxt   = MD_IDLE;
      end
      default: begin
        st_nxt = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MD_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    ud_r  <= ud_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

@@ bench/brent_root_finder_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for brent_root_finder_unit: drives bracketed searches against
// known functions, predicts every result in Q31.32 and compares. Depends on brf_pkg.
module brent_root_finder_unit_tb;
  import brf_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     SETTLE      = 800;
  localparam int     PER_PHASE   = 142;

  typedef struct {
    req_t kind;
    q_t   lo;
    q_t   hi;
    q_t   fv;
  } query_t;

  typedef struct {
    q_t point;
    bit done;
  } answer_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [TOL_W-1:0] cfg_abs_tolerance = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic            in_req_type = 1'b0;
  q_t              in_left_end = '0;
  q_t              in_right_end = '0;
  q_t              in_fun_value = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  q_t              out_point;
  logic            out_finished;

  brent_root_finder_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_abs_tolerance(cfg_abs_tolerance),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_left_end(in_left_end), .in_right_end(in_right_end), .in_fun_value(in_fun_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_point(out_point),
    .out_finished(out_finished)
  );

  always #5 clk = ~clk;

  query_t  query_q[$];
  answer_t answer_q[$];
  int      snd_idle = 0;
  int      rcv_idle = 0;
  int      mismatches = 0;
  int      sent_items = 0;
  int      results_seen = 0;
  int      roots_seen = 0;
  int      tol_settings = 1;
  longint  cycles = 0;

  // Predictor state.
  logic [TOL_W-1:0] tol_reg;
  q_t     prev_pt, best_pt, contra_pt, prev_f, best_f, contra_f, step_cur, step_old;
  phase_t solver_phase;

  function automatic logic [63:0] mag_of(input q_t x);
    return x[63] ? (64'd0 - 64'(x)) : 64'(x);
  endfunction

  function automatic q_t sat_pack(input bit neg, input logic [63:0] m);
    if (neg) return m[63] ? Q_MIN : q_t'(64'd0 - m);
    return m[63] ? Q_MAX : q_t'(m);
  endfunction

  function automatic q_t sat_abs(input q_t x);
    return sat_pack(1'b0, mag_of(x));
  endfunction

  function automatic q_t sat_add(input q_t x, input q_t y);
    logic signed [64:0] s;
    s = {x[63], x} + {y[63], y};
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return s[63:0];
  endfunction

  function automatic q_t sat_sub(input q_t x, input q_t y);
    logic signed [64:0] s;
    s = {x[63], x} - {y[63], y};
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return s[63:0];
  endfunction

  function automatic q_t fx_mul(input q_t x, input q_t y);
    logic [127:0] p;
    logic [63:0]  r;
    p = {64'd0, mag_of(x)} * {64'd0, mag_of(y)};
    r = p[95:32];
    if (p[127:96] != 0) r = '1;
    return sat_pack(x[63] != y[63], r);
  endfunction

  function automatic q_t fx_div(input q_t n, input q_t d);
    logic [63:0]  un, ud;
    logic [127:0] quo;
    un = mag_of(n);
    ud = mag_of(d);
    if (ud == 0) begin
      if (un == 0) return '0;
      return n[63] ? Q_MIN : Q_MAX;
    end
    if ({32'd0, un[63:32]} >= ud) return sat_pack(n[63] != d[63], '1);
    quo = {32'd0, un, 32'd0} / {64'd0, ud};
    return sat_pack(n[63] != d[63], quo[63:0]);
  endfunction

  // One pass of the Brent-Dekker loop body; returns the next point or the root.
  function automatic void brent_iterate(output q_t pt, output bit done);
    q_t tol1, xm, t, p, q, r, s, xm2;
    logic [63:0] diff;
    if (sat_abs(contra_f) < sat_abs(best_f)) begin
      prev_pt = best_pt;  best_pt = contra_pt;  contra_pt = prev_pt;
      prev_f  = best_f;   best_f  = contra_f;   contra_f  = prev_f;
    end
    tol1 = q_t'({1'b0, tol_reg} >> 1) + 1;
    diff = 64'(contra_pt) - 64'(best_pt);
    xm = {contra_pt < best_pt, diff[63:1]};
    if (sat_abs(xm) <= tol1 || best_f == 0) begin
      pt = best_pt;
      done = 1'b1;
      solver_phase = PH_IDLE;
      return;
    end
    if (sat_abs(step_old) < tol1 || sat_abs(prev_f) < sat_abs(best_f)) begin
      step_cur = xm;
      step_old = xm;
    end else begin
      xm2 = sat_add(xm, xm);
      if (prev_pt != contra_pt) begin
        // Inverse quadratic interpolation.
        q = fx_div(prev_f, contra_f);
        r = fx_div(best_f, contra_f);
        s = fx_div(best_f, prev_f);
        t = sat_sub(fx_mul(fx_mul(xm2, q), sat_sub(q, r)),
                    fx_mul(sat_sub(best_pt, prev_pt), sat_sub(r, Q_ONE)));
        p = fx_mul(s, t);
        q = fx_mul(fx_mul(sat_sub(q, Q_ONE), sat_sub(r, Q_ONE)), sat_sub(s, Q_ONE));
      end else begin
        s = fx_div(best_f, prev_f);
        p = fx_mul(xm2, s);
        q = sat_sub(Q_ONE, s);
      end
      if (p > 0) q = sat_sub('0, q);
      p = sat_abs(p);
      t = sat_sub(fx_mul(sat_add(sat_add(xm, xm), xm), q), sat_abs(fx_mul(tol1, q)));
      if (sat_add(p, p) < t && p < q_t'(64'(sat_abs(fx_mul(step_old, q))) >> 1)) begin
        step_old = step_cur;
        step_cur = fx_div(p, q);
      end else begin
        step_cur = xm;
        step_old = xm;
      end
    end
    prev_pt = best_pt;
    prev_f  = best_f;
    if (sat_abs(step_cur) > tol1) best_pt = sat_add(best_pt, step_cur);
    else if (xm >= 0)             best_pt = sat_add(best_pt, tol1);
    else                          best_pt = sat_sub(best_pt, tol1);
    pt = best_pt;
    done = 1'b0;
    solver_phase = PH_ITER;
  endfunction

  function automatic bit solver_step(input query_t it, output q_t pt, output bit done);
    pt = '0;
    done = 1'b0;
    if (it.kind == REQ_START) begin
      prev_pt = it.lo;
      best_pt = it.hi;
      solver_phase = PH_LEFT;
      pt = prev_pt;
      return 1'b1;
    end
    case (solver_phase)
      PH_LEFT: begin
        prev_f = it.fv;
        solver_phase = PH_RIGHT;
        pt = best_pt;
        return 1'b1;
      end
      PH_RIGHT: begin
        best_f = it.fv;
        contra_pt = prev_pt;
        contra_f = prev_f;
        step_cur = sat_sub(best_pt, prev_pt);
        step_old = step_cur;
        brent_iterate(pt, done);
        return 1'b1;
      end
      PH_ITER: begin
        best_f = it.fv;
        if ((best_f > 0 && contra_f > 0) || (best_f < 0 && contra_f < 0)) begin
          contra_pt = prev_pt;
          contra_f = prev_f;
          step_cur = sat_sub(best_pt, prev_pt);
          step_old = step_cur;
        end
        brent_iterate(pt, done);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Queues one transaction and its expected result, if it causes one.
  task automatic post(input req_t kind, input q_t lo, input q_t hi, input q_t fv,
                      output q_t pt, output bit done);
    query_t  it;
    answer_t ans;
    it.kind = kind;  it.lo = lo;  it.hi = hi;  it.fv = fv;
    if (solver_step(it, ans.point, ans.done)) begin
      answer_q.push_back(ans);
      sent_items++;
    end
    pt = ans.point;
    done = ans.done;
    query_q.push_back(it);
  endtask

  function automatic q_t rnd_q();
    return q_t'({$urandom, $urandom}) >>> $urandom_range(0, 63);
  endfunction

  function automatic q_t probe_fn(input int shape, input q_t root, input q_t k, input q_t x);
    q_t d;
    d = sat_sub(x, root);
    case (shape)
      0:       return fx_mul(k, d);
      1:       return fx_mul(d, sat_abs(d));
      default: return sat_add(fx_mul(k, d), k);
    endcase
  endfunction

  // A full search against a known function, cut short after a number of steps.
  task automatic run_search();
    q_t root, k, lo, hi, pt, tmp;
    int shape, steps;
    bit done;
    root = rnd_q();
    k = rnd_q();
    shape = ($urandom_range(0, 9) == 0) ? 2 : $urandom_range(0, 1);
    lo = sat_sub(root, sat_abs(rnd_q()));
    hi = sat_add(root, sat_abs(rnd_q()));
    if ($urandom_range(0, 1)) begin
      tmp = lo;  lo = hi;  hi = tmp;
    end
    post(REQ_START, lo, hi, rnd_q(), pt, done);
    steps = $urandom_range(3, 45);
    while (steps > 0) begin
      post(REQ_VALUE, rnd_q(), rnd_q(), probe_fn(shape, root, k, pt), pt, done);
      if (done) break;
      steps--;
    end
  endtask

  task automatic drain();
    while (query_q.size() != 0 || in_valid || answer_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_tol(input logic [TOL_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_abs_tolerance <= v;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    cfg_valid <= 1'b0;
    tol_reg = v;
    tol_settings++;
  endtask

  task automatic directed_items();
    q_t pt;
    bit done;
    post(REQ_VALUE, Q_MAX, Q_MIN, Q_MIN, pt, done);
    post(REQ_START, Q_MIN, Q_MAX, '0, pt, done);
    post(REQ_VALUE, '0, '0, Q_MAX, pt, done);
    post(REQ_VALUE, '0, '0, Q_MIN, pt, done);
    post(REQ_VALUE, '0, '0, '1, pt, done);
    post(REQ_VALUE, '0, '0, Q_MAX, pt, done);
    post(REQ_START, Q_MAX, Q_MIN, Q_MAX, pt, done);
    post(REQ_VALUE, '0, '0, '0, pt, done);
    post(REQ_VALUE, '0, '0, Q_ONE, pt, done);
    post(REQ_VALUE, '0, '0, Q_MIN, pt, done);
    post(REQ_START, '0, '0, '0, pt, done);
    post(REQ_VALUE, '0, '0, Q_ONE, pt, done);
    post(REQ_VALUE, '0, '0, -Q_ONE, pt, done);
    post(REQ_START, -Q_ONE, Q_ONE, '0, pt, done);
    post(REQ_VALUE, '0, '0, -Q_ONE, pt, done);
    post(REQ_VALUE, '0, '0, Q_ONE, pt, done);
    // A start in the middle of a search restarts it.
    post(REQ_START, Q_ONE, Q_MAX, '0, pt, done);
    post(REQ_VALUE, '0, '0, Q_MIN, pt, done);
    post(REQ_VALUE, '0, '0, Q_MIN, pt, done);
    post(REQ_VALUE, '0, '0, '0, pt, done);
    post(REQ_VALUE, '0, '0, '0, pt, done);
  endtask

  task automatic random_items(input int count);
    q_t pt;
    bit done;
    int goal;
    goal = sent_items + count;
    while (sent_items < goal) begin
      if ($urandom_range(0, 99) < 85) run_search();
      else post($urandom_range(0, 3) == 0 ? REQ_START : REQ_VALUE,
                q_t'({$urandom, $urandom}), q_t'({$urandom, $urandom}),
                q_t'({$urandom, $urandom}), pt, done);
    end
  endtask

  // Sender: holds a transaction until accepted, idles at random between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (query_q.size() != 0 && $urandom_range(0, 99) >= snd_idle) begin
        in_req_type  <= query_q[0].kind;
        in_left_end  <= query_q[0].lo;
        in_right_end <= query_q[0].hi;
        in_fun_value <= query_q[0].fv;
        in_valid     <= 1'b1;
        void'(query_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= rcv_idle);
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_finished) roots_seen++;
      if (answer_q.size() == 0) begin
        $error("unexpected result: point %h finished %0d", out_point, out_finished);
        mismatches++;
      end else begin
        if (out_point !== answer_q[0].point) begin
          $error("point: expected %h, actual %h", answer_q[0].point, out_point);
          mismatches++;
        end
        if (out_finished !== answer_q[0].done) begin
          $error("finished: expected %0d, actual %0d", answer_q[0].done, out_finished);
          mismatches++;
        end
        void'(answer_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [TOL_W-1:0] tol_plan [5];
    tol_plan[0] = '0;
    tol_plan[1] = '1;
    tol_plan[2] = TOL_W'({$urandom, $urandom}) >> $urandom_range(20, 40);
    tol_plan[3] = TOL_W'(1);
    tol_plan[4] = TOL_W'($urandom_range(1, 1 << 20));
    tol_reg = TOL_W'(65536);
    prev_pt = '0;  best_pt = '0;  contra_pt = '0;
    prev_f = '0;   best_f = '0;   contra_f = '0;
    step_cur = '0; step_old = '0;
    solver_phase = PH_IDLE;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    snd_idle = 17;
    rcv_idle = 70;
    directed_items();
    random_items(PER_PHASE - 20);
    for (int ph = 0; ph < 5; ph++) begin
      // Every phase boundary holds the sender until all results are back.
      drain();
      write_tol(tol_plan[ph]);
      snd_idle = (ph < 1) ? 17 : (ph < 3) ? 70 : 0;
      rcv_idle = (ph < 1) ? 70 : (ph < 3) ? 17 : 0;
      random_items(PER_PHASE);
    end
    drain();
    if (answer_q.size() != 0) mismatches++;
    $display("Checked %0d transactions with %0d results, %0d of them roots,",
             sent_items, results_seen, roots_seen);
    $display("across %0d tolerance settings and three idling patterns.", tol_settings);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
